[rtl/spa_pkg.sv]
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants of the sparse polynomial adder
// Term layout, store sizing, request codes and the store access request.
// ----------------------------------------------------------------------------
package spa_pkg;

  // Store capacity in terms, and the widths that follow from it.
  localparam int MAX_TERMS = 32;
  localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);

  // Field widths of the request and result channels.
  localparam int COEF_W = 16;
  localparam int EXPO_W = 16;
  localparam int SUM_W  = COEF_W + 1;
  localparam int OP_W   = 2;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_MERGE       = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  // One stored term: coefficient in the upper half, exponent in the lower.
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXPO_W-1:0]        expo;
  } term_t;

  // Access request from the sequencer to one term store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    term_t             wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[rtl/sparse_polynomial_adder.sv]
// ----------------------------------------------------------------------------
// sparse_polynomial_adder: merge of two sparse polynomials
// Usage:
//   A request is taken at a rising edge with start high and busy low. Its op
//   loads one term (in_coefficient, in_exponent) into the first or second
//   store, or merges both stores. Loads give no result and are dropped
//   once a store holds MAX_TERMS terms. Unused op codes are ignored.
//   A merge emits the result terms on the out_ ports, one per cycle with
//   out_valid high for that cycle; the first term is registered once both
//   heads have been read from the stores, and the final term carries
//   out_is_last. A merge keeps busy high while it reads one head of each
//   term store per cycle; busy drops once the last term is registered.
//   When both stores are empty a single result with out_is_empty and
//   out_is_last set appears the cycle after the request. A merge leaves
//   both stores empty.
//   Results cannot be held off by the receiver: each is shown for one cycle.
//   Synchronous active-low reset empties both stores and returns to idle;
//   store contents are not cleared.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [spa_pkg::OP_W-1:0]          in_op,
  input  logic signed [spa_pkg::COEF_W-1:0] in_coefficient,
  input  logic [spa_pkg::EXPO_W-1:0]        in_exponent,
  output logic                              out_valid,
  output logic signed [spa_pkg::SUM_W-1:0]  out_sum_coefficient,
  output logic [spa_pkg::EXPO_W-1:0]        out_sum_exponent,
  output logic                              out_is_last,
  output logic                              out_is_empty
);
  import spa_pkg::*;

  mem_req_t first_req, second_req;
  term_t    first_rd, second_rd;

  // Term stores for the two polynomials.
  spa_term_mem u_first_mem (
    .clk     (clk),
    .req     (first_req),
    .rd_data (first_rd)
  );

  spa_term_mem u_second_mem (
    .clk     (clk),
    .req     (second_req),
    .rd_data (second_rd)
  );

  // Load and merge sequencer.
  spa_merge_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_coefficient      (in_coefficient),
    .in_exponent         (in_exponent),
    .first_req           (first_req),
    .second_req          (second_req),
    .first_rd            (first_rd),
    .second_rd           (second_rd),
    .out_valid           (out_valid),
    .out_sum_coefficient (out_sum_coefficient),
    .out_sum_exponent    (out_sum_exponent),
    .out_is_last         (out_is_last),
    .out_is_empty        (out_is_empty)
  );

endmodule

[rtl/spa_term_mem.sv]
// ----------------------------------------------------------------------------
// spa_term_mem: term store
// Single-port write, single-port read memory with a registered read.
// ----------------------------------------------------------------------------
module spa_term_mem (
  input  logic             clk,
  input  spa_pkg::mem_req_t req,
  output spa_pkg::term_t    rd_data
);
  import spa_pkg::*;

  term_t mem [MAX_TERMS];
  term_t rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/spa_merge_ctrl.sv]
// ----------------------------------------------------------------------------
// spa_merge_ctrl: load and merge sequencer
// Appends terms to the two stores and walks both stores two-pointer style,
// emitting one result term per cycle during a merge.
// ----------------------------------------------------------------------------
module spa_merge_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [spa_pkg::OP_W-1:0]         in_op,
  input  logic signed [spa_pkg::COEF_W-1:0] in_coefficient,
  input  logic [spa_pkg::EXPO_W-1:0]       in_exponent,
  output spa_pkg::mem_req_t                first_req,
  output spa_pkg::mem_req_t                second_req,
  input  spa_pkg::term_t                   first_rd,
  input  spa_pkg::term_t                   second_rd,
  output logic                             out_valid,
  output logic signed [spa_pkg::SUM_W-1:0] out_sum_coefficient,
  output logic [spa_pkg::EXPO_W-1:0]       out_sum_exponent,
  output logic                             out_is_last,
  output logic                             out_is_empty
);
  import spa_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt1_r, cnt1_nxt, cnt2_r, cnt2_nxt;
  logic [CNT_W-1:0] n1_r, n1_nxt, n2_r, n2_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic             valid_r, valid_nxt;
  logic signed [SUM_W-1:0] coef_r, coef_nxt;
  logic [EXPO_W-1:0] expo_r, expo_nxt;
  logic             last_r, last_nxt;
  logic             empty_r, empty_nxt;

  op_t   op;
  term_t load_term;
  logic  a_ok, b_ok, a_gt, a_lt, adv_a, adv_b;
  logic signed [SUM_W-1:0] a_ext, b_ext;

  assign op        = op_t'(in_op);
  assign load_term = '{coef: in_coefficient, expo: in_exponent};

  // Head comparison over the two read ports.
  assign a_ok  = (i_r < n1_r);
  assign b_ok  = (j_r < n2_r);
  assign a_gt  = (first_rd.expo > second_rd.expo);
  assign a_lt  = (first_rd.expo < second_rd.expo);
  assign adv_a = a_ok && (!b_ok || !a_lt);
  assign adv_b = b_ok && (!a_ok || !a_gt);
  assign a_ext = SUM_W'(first_rd.coef);
  assign b_ext = SUM_W'(second_rd.coef);

  // Next-state logic for loads and the merge walk.
  always_comb begin
    state_nxt = state_r;
    cnt1_nxt  = cnt1_r;
    cnt2_nxt  = cnt2_r;
    n1_nxt    = n1_r;
    n2_nxt    = n2_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    valid_nxt = 1'b0;
    coef_nxt  = coef_r;
    expo_nxt  = expo_r;
    last_nxt  = last_r;
    empty_nxt = empty_r;
    first_req  = '{we: 1'b0, waddr: cnt1_r[ADDR_W-1:0], wdata: load_term, raddr: '0};
    second_req = '{we: 1'b0, waddr: cnt2_r[ADDR_W-1:0], wdata: load_term, raddr: '0};

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_LOAD_FIRST: begin
              if (cnt1_r < CNT_W'(MAX_TERMS)) begin
                first_req.we = 1'b1;
                cnt1_nxt     = cnt1_r + CNT_W'(1);
              end
            end
            OP_LOAD_SECOND: begin
              if (cnt2_r < CNT_W'(MAX_TERMS)) begin
                second_req.we = 1'b1;
                cnt2_nxt      = cnt2_r + CNT_W'(1);
              end
            end
            OP_MERGE: begin
              n1_nxt   = cnt1_r;
              n2_nxt   = cnt2_r;
              cnt1_nxt = '0;
              cnt2_nxt = '0;
              i_nxt    = '0;
              j_nxt    = '0;
              if (cnt1_r == '0 && cnt2_r == '0) begin
                // Both lists empty: a single flagged result.
                valid_nxt = 1'b1;
                coef_nxt  = '0;
                expo_nxt  = '0;
                last_nxt  = 1'b1;
                empty_nxt = 1'b1;
              end else begin
                state_nxt = ST_MERGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MERGE: begin
        // Emit the higher head, or the sum of two equal heads.
        i_nxt     = i_r + CNT_W'(adv_a);
        j_nxt     = j_r + CNT_W'(adv_b);
        valid_nxt = 1'b1;
        empty_nxt = 1'b0;
        if (adv_a && adv_b) begin
          coef_nxt = a_ext + b_ext;
          expo_nxt = first_rd.expo;
        end else if (adv_a) begin
          coef_nxt = a_ext;
          expo_nxt = first_rd.expo;
        end else begin
          coef_nxt = b_ext;
          expo_nxt = second_rd.expo;
        end
        last_nxt = (i_nxt >= n1_r) && (j_nxt >= n2_r);
        if (last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Read addresses follow the next pointers so the heads arrive in time.
    first_req.raddr  = i_nxt[ADDR_W-1:0];
    second_req.raddr = j_nxt[ADDR_W-1:0];
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt1_r  <= '0;
      cnt2_r  <= '0;
      n1_r    <= '0;
      n2_r    <= '0;
      i_r     <= '0;
      j_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt1_r  <= cnt1_nxt;
      cnt2_r  <= cnt2_nxt;
      n1_r    <= n1_nxt;
      n2_r    <= n2_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      valid_r <= valid_nxt;
    end
    coef_r  <= coef_nxt;
    expo_r  <= expo_nxt;
    last_r  <= last_nxt;
    empty_r <= empty_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = valid_r;
  assign out_sum_coefficient = coef_r;
  assign out_sum_exponent    = expo_r;
  assign out_is_last         = last_r;
  assign out_is_empty        = empty_r;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sparse polynomial adder
// Loads two term lists per round, issues a merge and compares every emitted
// term against a local model of the two term stores. Covers field extremes,
// zero sums, tails from either list, empty merges, full stores, unused op
// codes and unordered loads, then random rounds under varying request gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import spa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 125;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 16'sh8000;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7FFF;

  // One emitted term as it appears on the result ports.
  typedef struct packed {
    logic signed [SUM_W-1:0] coef;
    logic [EXPO_W-1:0]       expo;
    logic                    is_last;
    logic                    is_empty;
  } sum_term_t;

  logic                     clk;
  logic                     rst_n          = 1'b0;
  logic                     start          = 1'b0;
  logic [OP_W-1:0]          in_op          = OP_NONE;
  logic signed [COEF_W-1:0] in_coefficient = '0;
  logic [EXPO_W-1:0]        in_exponent    = '0;
  logic                     busy;
  logic                     out_valid;
  logic signed [SUM_W-1:0]  out_sum_coefficient;
  logic [EXPO_W-1:0]        out_sum_exponent;
  logic                     out_is_last;
  logic                     out_is_empty;

  // Local copy of the two term stores and the terms still to come out.
  term_t     first_store[MAX_TERMS];
  term_t     second_store[MAX_TERMS];
  int        first_len  = 0;
  int        second_len = 0;
  sum_term_t due_terms[$];

  int mismatches      = 0;
  int requests_sent   = 0;
  int ignored_sent    = 0;
  int merges_sent     = 0;
  int results_checked = 0;
  int quiet_cycles    = 0;
  int idle_pct        = 0;

  sparse_polynomial_adder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_coefficient      (in_coefficient),
    .in_exponent         (in_exponent),
    .out_valid           (out_valid),
    .out_sum_coefficient (out_sum_coefficient),
    .out_sum_exponent    (out_sum_exponent),
    .out_is_last         (out_is_last),
    .out_is_empty        (out_is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A term that passes through the merge unchanged, widened to the sum width.
  function automatic sum_term_t lone_term(term_t t);
    return '{coef: {t.coef[COEF_W-1], t.coef}, expo: t.expo, is_last: 1'b0,
             is_empty: 1'b0};
  endfunction

  // Updates the store model for one accepted request and queues the terms
  // that a merge will emit.
  function automatic void apply_request(op_t op, term_t t);
    sum_term_t merged[$];
    term_t     a;
    term_t     b;
    int        i;
    int        j;
    i = 0;
    j = 0;
    case (op)
      OP_LOAD_FIRST: begin
        if (first_len < MAX_TERMS) begin
          first_store[first_len] = t;
          first_len++;
        end
      end
      OP_LOAD_SECOND: begin
        if (second_len < MAX_TERMS) begin
          second_store[second_len] = t;
          second_len++;
        end
      end
      OP_MERGE: begin
        if (first_len == 0 && second_len == 0) begin
          merged.push_back('{coef: '0, expo: '0, is_last: 1'b1, is_empty: 1'b1});
        end
        // Walk both heads; the higher exponent goes first, equal ones add up.
        while (i < first_len && j < second_len) begin
          a = first_store[i];
          b = second_store[j];
          if (a.expo > b.expo) begin
            merged.push_back(lone_term(a));
            i++;
          end else if (a.expo < b.expo) begin
            merged.push_back(lone_term(b));
            j++;
          end else begin
            merged.push_back('{coef: {a.coef[COEF_W-1], a.coef} + {b.coef[COEF_W-1], b.coef},
                               expo: a.expo, is_last: 1'b0, is_empty: 1'b0});
            i++;
            j++;
          end
        end
        // Whatever is left of either list follows in store order.
        for (; i < first_len; i++) merged.push_back(lone_term(first_store[i]));
        for (; j < second_len; j++) merged.push_back(lone_term(second_store[j]));
        merged[merged.size() - 1].is_last = 1'b1;
        foreach (merged[k]) due_terms.push_back(merged[k]);
        first_len  = 0;
        second_len = 0;
      end
      default: ;
    endcase
  endfunction

  // Coefficients lean on the extremes and on zero.
  function automatic logic signed [COEF_W-1:0] rand_coefficient();
    case ($urandom_range(9))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return '0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // Drives one request, waits until it is taken and may then leave a gap.
  // Start is only lowered for a gap, so a back-to-back request keeps it high.
  // Each further idle cycle follows at the same rate, so about idle_pct of
  // the sending cycles stay idle.
  task automatic send_request(op_t op, logic signed [COEF_W-1:0] coef,
                              logic [EXPO_W-1:0] expo);
    in_op          <= op;
    in_coefficient <= coef;
    in_exponent    <= expo;
    start          <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    apply_request(op, '{coef: coef, expo: expo});
    if (op == OP_NONE) ignored_sent++;
    else requests_sent++;
    if (op == OP_MERGE) merges_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Builds two descending term lists that share some exponents, loads them
  // interleaved with the odd unused op code, and merges. Unordered rounds use
  // a tiny exponent range so that order breaks and exponents repeat.
  task automatic send_polynomial_pair(int n_first, int n_second, bit narrow,
                                      bit unordered);
    term_t first_q[$];
    term_t second_q[$];
    term_t t;
    term_t u;
    int    f_left;
    int    s_left;
    int    gap_max;
    int    cur;
    int    pick;
    f_left  = n_first;
    s_left  = n_second;
    gap_max = narrow ? 2 : 65535 / (n_first + n_second + 1);
    cur     = $urandom_range(65535, (n_first + n_second) * gap_max);
    while (f_left > 0 || s_left > 0) begin
      cur   -= $urandom_range(gap_max, 1);
      t.expo = unordered ? EXPO_W'($urandom_range(7)) : EXPO_W'(cur);
      t.coef = rand_coefficient();
      if (f_left == 0) pick = 1;
      else if (s_left == 0) pick = 0;
      else pick = $urandom_range(2);
      if (pick != 1) begin
        first_q.push_back(t);
        f_left--;
      end
      if (pick != 0) begin
        // A shared exponent cancels now and then to give a zero sum.
        u      = t;
        u.coef = ($urandom_range(2) == 0 && t.coef != COEF_MIN) ? -t.coef
                                                                 : rand_coefficient();
        second_q.push_back(u);
        s_left--;
      end
    end
    while (first_q.size() > 0 || second_q.size() > 0) begin
      if ($urandom_range(15) == 0) begin
        send_request(OP_NONE, rand_coefficient(), EXPO_W'($urandom));
      end
      if (second_q.size() == 0 || (first_q.size() > 0 && $urandom_range(1) == 1)) begin
        t = first_q.pop_front();
        send_request(OP_LOAD_FIRST, t.coef, t.expo);
      end else begin
        t = second_q.pop_front();
        send_request(OP_LOAD_SECOND, t.coef, t.expo);
      end
    end
    send_request(OP_MERGE, rand_coefficient(), EXPO_W'($urandom));
  endtask

  // A merge with both stores empty, right after reset.
  task automatic test_empty_merge();
    send_request(OP_MERGE, COEF_MIN, '1);
  endtask

  // Largest and smallest sums, a zero sum and a tail from the first list.
  task automatic test_field_extremes();
    send_request(OP_LOAD_FIRST,  COEF_MAX, 16'hFFFF);
    send_request(OP_LOAD_SECOND, COEF_MAX, 16'hFFFF);
    send_request(OP_LOAD_FIRST,  COEF_MIN, 16'd300);
    send_request(OP_LOAD_SECOND, COEF_MIN, 16'd300);
    send_request(OP_LOAD_FIRST,  16'sd7,   16'd100);
    send_request(OP_LOAD_SECOND, -16'sd7,  16'd100);
    send_request(OP_LOAD_SECOND, -16'sd5,  16'd50);
    send_request(OP_LOAD_FIRST,  16'sd1,   16'd0);
    send_request(OP_MERGE, '0, '0);
  endtask

  // The second list outlives the first.
  task automatic test_tail_of_second();
    send_request(OP_LOAD_FIRST,  16'sd3,  16'd10);
    send_request(OP_LOAD_SECOND, 16'sd4,  16'd20);
    send_request(OP_LOAD_SECOND, 16'sd2,  16'd10);
    send_request(OP_LOAD_SECOND, 16'sd9,  16'd5);
    send_request(OP_LOAD_SECOND, -16'sd1, 16'd0);
    send_request(OP_MERGE, COEF_MAX, 16'h8000);
  endtask

  // A single term in the first list only.
  task automatic test_single_list();
    send_request(OP_LOAD_FIRST, -16'sd1, 16'hFFFF);
    send_request(OP_MERGE, '0, '0);
  endtask

  // The unused op code must leave the stores alone.
  task automatic test_ignored_op();
    send_request(OP_LOAD_SECOND, 16'sd12, 16'd8);
    send_request(OP_NONE, COEF_MIN, 16'hFFFF);
    send_request(OP_MERGE, '0, '0);
  endtask

  // Ascending loads are merged as they come, without reordering.
  task automatic test_unordered_loads();
    send_request(OP_LOAD_FIRST,  16'sd1, 16'd5);
    send_request(OP_LOAD_FIRST,  16'sd2, 16'd9);
    send_request(OP_LOAD_SECOND, 16'sd3, 16'd7);
    send_request(OP_MERGE, '0, '0);
  endtask

  // Both stores overfilled; the extra loads are dropped.
  task automatic test_store_full();
    send_polynomial_pair(MAX_TERMS + 2, MAX_TERMS + 1, 1'b0, 1'b0);
  endtask

  // Random rounds, mostly small lists, with request gaps at the given rate.
  task automatic test_random_merges(int gap_pct, int n_items);
    int goal;
    int n1;
    int n2;
    idle_pct = gap_pct;
    goal     = requests_sent + n_items;
    while (requests_sent < goal) begin
      if ($urandom_range(15) == 0) begin
        n1 = $urandom_range(MAX_TERMS);
        n2 = $urandom_range(MAX_TERMS);
      end else begin
        n1 = $urandom_range(6);
        n2 = $urandom_range(6);
      end
      send_polynomial_pair(n1, n2, $urandom_range(1) == 1, $urandom_range(11) == 0);
    end
  endtask

  // Checks each result term against the oldest one still due.
  always @(posedge clk) begin
    sum_term_t got;
    sum_term_t want;
    if (rst_n && out_valid === 1'b1) begin
      got = {out_sum_coefficient, out_sum_exponent, out_is_last, out_is_empty};
      if (due_terms.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: coef %0d exp %0d last %0b empty %0b",
                 $time, got.coef, got.expo, got.is_last, got.is_empty);
      end else begin
        want = due_terms.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          $display("%0t: result mismatch: expected coef %0d exp %0d last %0b empty %0b",
                   $time, want.coef, want.expo, want.is_last, want.is_empty);
          $display("%0t:                  actual   coef %0d exp %0d last %0b empty %0b",
                   $time, got.coef, got.expo, got.is_last, got.is_empty);
        end
      end
    end
  end

  // Ends the run if neither a request nor a result is taken for too long.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** sparse_polynomial_adder: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_merge();
    test_field_extremes();
    test_tail_of_second();
    test_single_list();
    test_ignored_op();
    test_unordered_loads();
    test_store_full();
    test_random_merges(0, PHASE_ITEMS);
    test_random_merges(48, PHASE_ITEMS);
    test_random_merges(17, PHASE_ITEMS);
    start <= 1'b0;

    // Let the last merge finish, then watch a little longer for stray terms.
    while (due_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d load and merge requests (%0d merges) and %0d unused op codes.",
             requests_sent, merges_sent, ignored_sent);
    $display("Checked %0d result terms; %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("** sparse_polynomial_adder: PASSED **");
    end else begin
      $display("** sparse_polynomial_adder: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
rtl/spa_pkg.sv
rtl/spa_term_mem.sv
rtl/spa_merge_ctrl.sv
rtl/sparse_polynomial_adder.sv
bench/tb_top.sv
